// ===== hdl/bmace_pkg.sv =====
// bmace_pkg: shared types and constants for the axis code extractor.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package bmace_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COL,
        ST_ROW,
        ST_ALIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic col_step;
        logic col_last;
        logic row_step;
        logic align_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic last_row;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/bmace_if.sv =====
// bmace_row_if / bmace_code_if: valid/ready channels for row input and code results.
// Depends on bmace_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface bmace_row_if;
    logic                        valid;
    logic                        ready;
    logic [bmace_pkg::DATA_W-1:0] row_bits;
    logic [bmace_pkg::DATA_W-1:0] row_mask;
    logic [bmace_pkg::DATA_W-1:0] prior_row_code;
    logic                        last_row;

    modport source (output valid, row_bits, row_mask, prior_row_code, last_row, input ready);
    modport sink   (input valid, row_bits, row_mask, prior_row_code, last_row, output ready);
endinterface

interface bmace_code_if;
    logic                        valid;
    logic                        ready;
    logic [bmace_pkg::DATA_W-1:0] col_code_bits;
    logic [bmace_pkg::DATA_W-1:0] col_code_mask;
    logic [bmace_pkg::DATA_W-1:0] row_vote_bits;
    logic [bmace_pkg::DATA_W-1:0] row_code_mask;

    modport source (output valid, col_code_bits, col_code_mask, row_vote_bits, row_code_mask,
                    input ready);
    modport sink   (input valid, col_code_bits, col_code_mask, row_vote_bits, row_code_mask,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/bit_matrix_axis_code_extract_top.sv =====
// Axis code extractor, N = MATRIX_SIZE: one row per cycle while loading (rows are not accepted
// in the other states); on the last row a column pass votes over the N stored rows, a row pass
// votes over min(N,32) bit positions, alignment shifts both codes down to their lowest voted bit,
// and the hand-off loads the result register once it is free.
// Reset clears the sequencer, row counter and result valid; image and mask rows are
// undefined until written. Depends on bmace_pkg, bmace_if and the bmace_* modules.
`timescale 1ns / 1ps
`default_nettype none

module bit_matrix_axis_code_extract_top #(
    parameter int MATRIX_SIZE = 32
) (
    input  wire           clk,
    input  wire           rst_n,
    bmace_row_if.sink     row_chan,
    bmace_code_if.source  code_chan
);

    localparam int N  = MATRIX_SIZE;
    localparam int W  = (MATRIX_SIZE < bmace_pkg::DATA_W) ? MATRIX_SIZE : bmace_pkg::DATA_W;
    localparam int IW = $clog2(MATRIX_SIZE);

    bmace_pkg::cmd_t    cmd;
    bmace_pkg::status_t status;
    logic [IW-1:0]      wr_idx;
    logic [IW-1:0]      step_idx;
    logic [W-1:0]       head_img, head_msk;
    logic [N-1:0]       col_img, col_msk;
    logic               out_free;

    assign status.in_valid = row_chan.valid;
    assign status.last_row = row_chan.last_row;
    assign status.out_free = out_free;

    bmace_ctrl #(.N(N), .W(W), .IW(IW)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .in_ready (row_chan.ready),
        .cmd      (cmd),
        .wr_idx   (wr_idx),
        .step_idx (step_idx)
    );

    bmace_store #(.N(N), .W(W), .IW(IW)) u_store (
        .clk      (clk),
        .cmd      (cmd),
        .wr_idx   (wr_idx),
        .wr_img   (row_chan.row_bits[W-1:0]),
        .wr_msk   (row_chan.row_mask[W-1:0]),
        .head_img (head_img),
        .head_msk (head_msk),
        .col_img  (col_img),
        .col_msk  (col_msk)
    );

    bmace_dp #(.N(N), .W(W), .IW(IW)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .step_idx      (step_idx),
        .seed          (row_chan.prior_row_code[W-1:0]),
        .head_img      (head_img),
        .head_msk      (head_msk),
        .col_img       (col_img),
        .col_msk       (col_msk),
        .out_ready     (code_chan.ready),
        .out_valid     (code_chan.valid),
        .out_free      (out_free),
        .col_code_bits (code_chan.col_code_bits),
        .col_code_mask (code_chan.col_code_mask),
        .row_vote_bits (code_chan.row_vote_bits),
        .row_code_mask (code_chan.row_code_mask)
    );

endmodule

`default_nettype wire

// ===== hdl/bmace_ctrl.sv =====
// bmace_ctrl: sequencer for row loading, the two voting passes, alignment and result hand-off.
// Depends on bmace_pkg (state_t, cmd_t, status_t).
`timescale 1ns / 1ps
`default_nettype none

module bmace_ctrl #(
    parameter int N  = 32,
    parameter int W  = 32,
    parameter int IW = 5
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  bmace_pkg::status_t  status,
    output logic                in_ready,
    output bmace_pkg::cmd_t     cmd,
    output logic [IW-1:0]       wr_idx,
    output logic [IW-1:0]       step_idx
);

    bmace_pkg::state_t state_reg, state_next;
    logic [IW-1:0]     row_count_reg, row_count_next;
    logic [IW-1:0]     step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmace_pkg::ST_LOAD;
            row_count_reg <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            step_reg      <= step_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        step_next      = step_reg;
        case (state_reg)
            bmace_pkg::ST_LOAD:
            begin
                if (status.in_valid)
                begin
                    if (status.last_row)
                    begin
                        state_next     = bmace_pkg::ST_COL;
                        row_count_next = '0;
                        step_next      = '0;
                    end
                    else if (row_count_reg == IW'(N - 1))
                        row_count_next = '0;
                    else
                        row_count_next = row_count_reg + 1'b1;
                end
            end
            bmace_pkg::ST_COL:
            begin
                if (step_reg == IW'(N - 1))
                begin
                    state_next = bmace_pkg::ST_ROW;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            bmace_pkg::ST_ROW:
            begin
                if (step_reg == IW'(W - 1))
                begin
                    state_next = bmace_pkg::ST_ALIGN;
                    step_next  = IW'(IW - 1);
                end
                else
                    step_next = step_reg + 1'b1;
            end
            bmace_pkg::ST_ALIGN:
            begin
                if (step_reg == '0)
                    state_next = bmace_pkg::ST_EMIT;
                else
                    step_next = step_reg - 1'b1;
            end
            bmace_pkg::ST_EMIT:
            begin
                if (status.out_free)
                    state_next = bmace_pkg::ST_LOAD;
            end
            default:
                state_next = bmace_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            bmace_pkg::ST_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.load  = status.in_valid;
                cmd.start = status.in_valid & status.last_row;
            end
            bmace_pkg::ST_COL:
            begin
                cmd.col_step = 1'b1;
                cmd.col_last = (step_reg == IW'(N - 1));
            end
            bmace_pkg::ST_ROW:
                cmd.row_step = 1'b1;
            bmace_pkg::ST_ALIGN:
                cmd.align_step = 1'b1;
            bmace_pkg::ST_EMIT:
                cmd.emit = status.out_free;
            default:
                cmd = '0;
        endcase
    end

    assign wr_idx   = row_count_reg;
    assign step_idx = step_reg;

endmodule

`default_nettype wire

// ===== hdl/bmace_store.sv =====
// bmace_store: image and mask row registers; rows rotate for the column pass,
// bits rotate within each row for the row pass. Depends on bmace_pkg (cmd_t).
`timescale 1ns / 1ps
`default_nettype none

module bmace_store #(
    parameter int N  = 32,
    parameter int W  = 32,
    parameter int IW = 5
) (
    input  wire              clk,
    input  bmace_pkg::cmd_t  cmd,
    input  wire [IW-1:0]     wr_idx,
    input  wire [W-1:0]      wr_img,
    input  wire [W-1:0]      wr_msk,
    output logic [W-1:0]     head_img,
    output logic [W-1:0]     head_msk,
    output logic [N-1:0]     col_img,
    output logic [N-1:0]     col_msk
);

    logic [W-1:0] img_reg [N];
    logic [W-1:0] msk_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_entry
        localparam int NXT = (i + 1) % N;

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                if (wr_idx == IW'(i))
                begin
                    img_reg[i] <= wr_img;
                    msk_reg[i] <= wr_msk;
                end
            end
            else if (cmd.col_step)
            begin
                img_reg[i] <= img_reg[NXT];
                msk_reg[i] <= msk_reg[NXT];
            end
            else if (cmd.row_step)
            begin
                img_reg[i] <= {img_reg[i][0], img_reg[i][W-1:1]};
                msk_reg[i] <= {msk_reg[i][0], msk_reg[i][W-1:1]};
            end
        end

        assign col_img[i] = img_reg[i][0];
        assign col_msk[i] = msk_reg[i][0];
    end

    assign head_img = img_reg[0];
    assign head_msk = msk_reg[0];

endmodule

`default_nettype wire

// ===== hdl/bmace_dp.sv =====
// bmace_dp: voting unit, running code, code/mask accumulators, alignment shifter
// and result register. Depends on bmace_pkg (cmd_t, DATA_W).
`timescale 1ns / 1ps
`default_nettype none

module bmace_dp #(
    parameter int N  = 32,
    parameter int W  = 32,
    parameter int IW = 5
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  bmace_pkg::cmd_t              cmd,
    input  wire [IW-1:0]                 step_idx,
    input  wire [W-1:0]                  seed,
    input  wire [W-1:0]                  head_img,
    input  wire [W-1:0]                  head_msk,
    input  wire [N-1:0]                  col_img,
    input  wire [N-1:0]                  col_msk,
    input  wire                          out_ready,
    output logic                         out_valid,
    output logic                         out_free,
    output logic [bmace_pkg::DATA_W-1:0] col_code_bits,
    output logic [bmace_pkg::DATA_W-1:0] col_code_mask,
    output logic [bmace_pkg::DATA_W-1:0] row_vote_bits,
    output logic [bmace_pkg::DATA_W-1:0] row_code_mask
);

    localparam int CNT_W = $clog2(N + 1);
    localparam int OW    = bmace_pkg::DATA_W;

    logic [N-1:0] code_reg, code_next;
    logic [N-1:0] cbits_reg, cbits_next;
    logic [N-1:0] cmask_reg, cmask_next;
    logic [N-1:0] rbits_reg, rbits_next;
    logic [N-1:0] rmask_reg, rmask_next;
    logic         out_valid_reg, out_valid_next;

    logic [OW-1:0] o_cbits_reg, o_cmask_reg, o_rbits_reg, o_rmask_reg;

    logic [N+W-1:0]  head_img_x, head_msk_x, seed_x;
    logic [N+OW-1:0] cbits_x, cmask_x, rbits_x, rmask_x;
    logic [N-1:0]    v_img, v_msk, new_code, low_mask;
    logic [CNT_W-1:0] total, diff;
    logic            inv, voted;
    logic            c_shift, r_shift;

    assign head_img_x = {{N{1'b0}}, head_img};
    assign head_msk_x = {{N{1'b0}}, head_msk};
    assign seed_x     = {{N{1'b0}}, seed};

    always_comb
    begin
        v_img    = cmd.col_step ? head_img_x[N-1:0] : col_img;
        v_msk    = cmd.col_step ? head_msk_x[N-1:0] : col_msk;
        total    = CNT_W'($countones(v_msk));
        diff     = CNT_W'($countones((code_reg ^ v_img) & v_msk));
        inv      = {diff, 1'b0} > {1'b0, total};
        voted    = |v_msk;
        new_code = (code_reg & ~v_msk) | ((inv ? ~v_img : v_img) & v_msk);
        low_mask = ~({N{1'b1}} << (1 << step_idx));
        c_shift  = (|cmask_reg) & ~(|(cmask_reg & low_mask));
        r_shift  = (|rmask_reg) & ~(|(rmask_reg & low_mask));
    end

    always_comb
    begin
        code_next      = code_reg;
        cbits_next     = cbits_reg;
        cmask_next     = cmask_reg;
        rbits_next     = rbits_reg;
        rmask_next     = rmask_reg;
        out_valid_next = out_valid_reg;

        if (cmd.start)
        begin
            code_next  = seed_x[N-1:0];
            cbits_next = '0;
            cmask_next = '0;
            rbits_next = '0;
            rmask_next = '0;
        end
        else if (cmd.col_step)
        begin
            cbits_next[step_idx] = inv;
            cmask_next[step_idx] = voted;
            code_next            = cmd.col_last ? cbits_next : new_code;
        end
        else if (cmd.row_step)
        begin
            rbits_next[step_idx] = inv;
            rmask_next[step_idx] = voted;
            code_next            = new_code;
        end
        else if (cmd.align_step)
        begin
            if (c_shift)
            begin
                cbits_next = cbits_reg >> (1 << step_idx);
                cmask_next = cmask_reg >> (1 << step_idx);
            end
            if (r_shift)
            begin
                rbits_next = rbits_reg >> (1 << step_idx);
                rmask_next = rmask_reg >> (1 << step_idx);
            end
        end

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        cbits_reg <= cbits_next;
        cmask_reg <= cmask_next;
        rbits_reg <= rbits_next;
        rmask_reg <= rmask_next;
    end

    assign cbits_x = {{OW{1'b0}}, cbits_reg};
    assign cmask_x = {{OW{1'b0}}, cmask_reg};
    assign rbits_x = {{OW{1'b0}}, rbits_reg};
    assign rmask_x = {{OW{1'b0}}, rmask_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_cbits_reg <= cbits_x[OW-1:0];
            o_cmask_reg <= cmask_x[OW-1:0];
            o_rbits_reg <= rbits_x[OW-1:0];
            o_rmask_reg <= rmask_x[OW-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_free      = ~out_valid_reg | out_ready;
    assign col_code_bits = o_cbits_reg;
    assign col_code_mask = o_cmask_reg;
    assign row_vote_bits = o_rbits_reg;
    assign row_code_mask = o_rmask_reg;

endmodule

`default_nettype wire

// ===== bench/bit_matrix_axis_code_extract_top_tb.sv =====
// Self-checking bench for bit_matrix_axis_code_extract_top: frames of image rows in, axis codes out,
// each result compared with an in-bench vote/transpose/align predictor under random back-pressure.
// Depends on bmace_pkg, bmace_if and the block's RTL.
`timescale 1ns / 1ps

module bit_matrix_axis_code_extract_top_tb;

    localparam int DATA_W = bmace_pkg::DATA_W;

    localparam int MATRIX_SIZE = 32;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef logic [DATA_W-1:0] plane_t [MATRIX_SIZE];

    typedef struct {
        logic [DATA_W-1:0] bits;
        logic [DATA_W-1:0] mask;
    } axis_code_t;

    typedef struct {
        logic [DATA_W-1:0] col_bits;
        logic [DATA_W-1:0] col_mask;
        logic [DATA_W-1:0] row_bits;
        logic [DATA_W-1:0] row_mask;
    } code_pair_t;

    logic clk;
    logic rst_n;

    bmace_row_if  row_chan ();
    bmace_code_if code_chan ();

    bit_matrix_axis_code_extract_top #(
        .MATRIX_SIZE (MATRIX_SIZE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_chan  (row_chan),
        .code_chan (code_chan)
    );

    plane_t     frame_pix;
    plane_t     frame_valid;
    int         row_slot;
    code_pair_t code_expect_q [$];

    int  errors;
    int  rows_sent;
    int  frames_sent;
    int  codes_checked;
    bit  no_idle;
    int  hold_req;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("bit_matrix_axis_code_extract_top_tb: FAIL");
        $finish;
    end

    function automatic axis_code_t vote_axis(logic [DATA_W-1:0] seed, plane_t pix, plane_t valid);
        axis_code_t        r;
        logic [DATA_W-1:0] code;
        int                total;
        int                diff;
        logic              flip;
        r.bits = '0;
        r.mask = '0;
        code   = seed;
        for (int i = 0; i < MATRIX_SIZE; i++)
        begin
            total = $countones(valid[i]);
            if (total != 0)
            begin
                diff      = $countones((code ^ pix[i]) & valid[i]);
                flip      = (2 * diff > total);
                r.bits[i] = flip;
                r.mask[i] = 1'b1;
                code      = (code & ~valid[i]) | ((flip ? ~pix[i] : pix[i]) & valid[i]);
            end
        end
        return r;
    endfunction

    function automatic axis_code_t align_code(axis_code_t c);
        int s;
        s = 0;
        if (c.mask != '0)
        begin
            while (!c.mask[s])
                s++;
        end
        c.bits = c.bits >> s;
        c.mask = c.mask >> s;
        return c;
    endfunction

    function automatic code_pair_t predict_codes(logic [DATA_W-1:0] seed);
        plane_t     tpix;
        plane_t     tvalid;
        axis_code_t col;
        axis_code_t row;
        code_pair_t p;
        for (int j = 0; j < MATRIX_SIZE; j++)
        begin
            for (int i = 0; i < MATRIX_SIZE; i++)
            begin
                tpix[j][i]   = frame_pix[i][j];
                tvalid[j][i] = frame_valid[i][j];
            end
        end
        col        = vote_axis(seed, frame_pix, frame_valid);
        row        = vote_axis(col.bits, tpix, tvalid);
        col        = align_code(col);
        row        = align_code(row);
        p.col_bits = col.bits;
        p.col_mask = col.mask;
        p.row_bits = row.bits;
        p.row_mask = row.mask;
        return p;
    endfunction

    function automatic logic [DATA_W-1:0] random_mask();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return '0;
        else if (pick < 30)
            return ALL_ONES;
        else if (pick < 40)
            return DATA_W'(1) << $urandom_range(DATA_W - 1);
        else if (pick < 50)
            return $urandom & $urandom;
        else
            return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        else if (pick < 16)
            return ALL_ONES;
        else
            return $urandom;
    endfunction

    // drive one row and hold it until the transfer; predictor updates on acceptance
    task automatic send_row(logic [DATA_W-1:0] bits, logic [DATA_W-1:0] mask,
                            logic [DATA_W-1:0] seed, logic last);
        row_chan.valid          <= 1'b1;
        row_chan.row_bits       <= bits;
        row_chan.row_mask       <= mask;
        row_chan.prior_row_code <= seed;
        row_chan.last_row       <= last;
        @(posedge clk);
        while (!row_chan.ready)
            @(posedge clk);
        frame_pix[row_slot]   = bits;
        frame_valid[row_slot] = mask;
        rows_sent++;
        if (last)
        begin
            code_expect_q.push_back(predict_codes(seed));
            row_slot = 0;
            frames_sent++;
        end
        else
        begin
            row_slot = (row_slot + 1) % MATRIX_SIZE;
        end
        if (!no_idle && $urandom_range(99) < 30)
        begin
            row_chan.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 30)
                @(posedge clk);
        end
    endtask

    task automatic send_frame(int len);
        logic [DATA_W-1:0] seed;
        seed = random_word();
        for (int k = 0; k < len; k++)
            send_row(random_word(), random_mask(), $urandom, 1'b0);
        send_row(random_word(), random_mask(), seed, 1'b1);
    endtask

    task automatic wait_codes();
        row_chan.valid <= 1'b0;
        while (code_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // first frame fills every entry; all masks empty, so neither code is shifted
    task automatic test_empty_masks();
        for (int k = 0; k < MATRIX_SIZE - 1; k++)
            send_row($urandom, '0, $urandom, 1'b0);
        send_row($urandom, '0, $urandom, 1'b1);
        wait_codes();
    endtask

    task automatic test_extremes();
        send_row(ALL_ONES, 32'h8000_0000, '0, 1'b1);
        send_row('0, ALL_ONES, ALL_ONES, 1'b1);
        send_row(32'h5555_5555, ALL_ONES, '0, 1'b1);
        send_row(32'hFFFF_0000, 32'hFFFF_0000, '0, 1'b0);
        send_row(32'h0F0F_0F0F, 32'h3333_3333, 32'hAAAA_AAAA, 1'b1);
        send_row($urandom, '0, $urandom, 1'b1);
        wait_codes();
    endtask

    task automatic test_random_frames();
        int pick;
        while (rows_sent < 1040)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame($urandom_range(0, 7));
            else if (pick < 85)
                send_frame($urandom_range(8, MATRIX_SIZE - 2));
            else if (pick < 95)
                send_frame(MATRIX_SIZE - 1);
            else
                send_frame($urandom_range(MATRIX_SIZE, MATRIX_SIZE + 8));
        end
        wait_codes();
    endtask

    // sink holds off while short frames keep coming, so the block backs up its input
    task automatic test_backpressure();
        hold_req = 400;
        for (int f = 0; f < 5; f++)
            send_frame($urandom_range(0, 3));
        wait_codes();
        repeat (20)
            @(posedge clk);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int f = 0; f < 6; f++)
            send_frame($urandom_range(0, 9));
        wait_codes();
        no_idle = 1'b0;
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        code_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                code_chan.ready <= 1'b0;
                hold_left--;
            end
            else if (!no_idle && $urandom_range(99) < 30)
                code_chan.ready <= 1'b0;
            else
                code_chan.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        code_pair_t        want;
        logic [DATA_W-1:0] got_f [4];
        logic [DATA_W-1:0] want_f [4];
        string             names [4];
        if (rst_n && code_chan.valid && code_chan.ready)
        begin
            if (code_expect_q.size() == 0)
            begin
                $display("%0t: unexpected code transfer: expected none, actual col %h/%h row %h/%h",
                         $time, code_chan.col_code_bits, code_chan.col_code_mask,
                         code_chan.row_vote_bits, code_chan.row_code_mask);
                errors++;
            end
            else
            begin
                want      = code_expect_q.pop_front();
                got_f     = '{code_chan.col_code_bits, code_chan.col_code_mask,
                              code_chan.row_vote_bits, code_chan.row_code_mask};
                want_f    = '{want.col_bits, want.col_mask, want.row_bits, want.row_mask};
                names     = '{"col_code_bits", "col_code_mask", "row_vote_bits", "row_code_mask"};
                for (int f = 0; f < 4; f++)
                begin
                    if (got_f[f] !== want_f[f])
                    begin
                        $display("%0t: %s mismatch: expected %h, actual %h", $time, names[f],
                                 want_f[f], got_f[f]);
                        errors++;
                    end
                end
                codes_checked++;
            end
        end
    end

    initial
    begin
        int n;
        errors                  = 0;
        rows_sent               = 0;
        frames_sent             = 0;
        codes_checked           = 0;
        no_idle                 = 1'b0;
        hold_req                = 0;
        row_slot                = 0;
        rst_n                   <= 1'b0;
        row_chan.valid          <= 1'b0;
        row_chan.row_bits       <= '0;
        row_chan.row_mask       <= '0;
        row_chan.prior_row_code <= '0;
        row_chan.last_row       <= 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_masks();
        test_extremes();
        test_backpressure();
        test_back_to_back();
        test_random_frames();

        row_chan.valid <= 1'b0;
        n = 0;
        while (code_expect_q.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        if (code_expect_q.size() != 0)
        begin
            $display("%0t: %0d expected code transfers never arrived", $time,
                     code_expect_q.size());
            errors++;
        end
        repeat (100)
            @(posedge clk);

        $display("Covered %0d rows in %0d frames (empty masks, extremes, wrap, early last row),",
                 rows_sent, frames_sent);
        $display("%0d code transfers checked under random and long back-pressure; %0d errors.",
                 codes_checked, errors);
        if (errors == 0)
            $display("bit_matrix_axis_code_extract_top_tb: PASS");
        else
            $display("bit_matrix_axis_code_extract_top_tb: FAIL");
        $finish;
    end

endmodule
